>>> hdl/swu_pkg.sv
`timescale 1ns / 1ps

package swu_pkg;

  localparam logic [7:0] SYNC_BYTE   = 8'h05;
  localparam logic [7:0] WRITE_FLAG  = 8'h80;
  localparam logic [7:0] CRC_POLY    = 8'h07;
  localparam logic [7:0] MASTER_ADDR = 8'hFF;

  localparam int unsigned WR_BODY_BYTES = 7;
  localparam int unsigned RD_BODY_BYTES = 3;
  localparam int unsigned REPLY_LAST    = 7;

  localparam logic KIND_TX    = 1'b0;
  localparam logic KIND_REPLY = 1'b1;

  localparam logic CFG_NODE_ADDRESS = 1'b0;
  localparam logic CFG_REPLY_SKIP   = 1'b1;

  typedef enum logic [1:0] {
    ACT_WRITE  = 2'd0,
    ACT_READ   = 2'd1,
    ACT_RXBYTE = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_SYNC  = 3'd1,
    ST_BAD_MASTER = 3'd2,
    ST_BAD_REG   = 3'd3,
    ST_BAD_CRC   = 3'd4
  } status_t;

  typedef struct packed {
    logic        done;
    logic [31:0] read_data;
    status_t     status;
  } reply_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
    logic [7:0] crc;
    crc = crc_in;
    for (int k = 0; k < 8; k++) begin
      if (crc[7] ^ data[k]) begin
        crc = {crc[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        crc = {crc[6:0], 1'b0};
      end
    end
    return crc;
  endfunction

endpackage

>>> hdl/swu_in_if.sv
`timescale 1ns / 1ps

interface swu_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [6:0]  reg_addr;
  logic [31:0] write_data;
  logic [7:0]  rx_byte;

  modport source (output valid, action, reg_addr, write_data, rx_byte, input ready);
  modport sink (input valid, action, reg_addr, write_data, rx_byte, output ready);
endinterface

>>> hdl/swu_out_if.sv
`timescale 1ns / 1ps

interface swu_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  tx_byte;
  logic        last;
  logic [31:0] read_data;
  logic [2:0]  reply_status;

  modport source (output valid, kind, tx_byte, last, read_data, reply_status, input ready);
  modport sink (input valid, kind, tx_byte, last, read_data, reply_status, output ready);
endinterface

>>> hdl/swu_reply_parser.sv
`timescale 1ns / 1ps

module swu_reply_parser
  import swu_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  logic [1:0]  action,
  input  logic [6:0]  reg_addr,
  input  logic [7:0]  rx_byte,
  input  logic [2:0]  skip_cfg,
  output reply_t      reply
);

  logic        pending_r, pending_nxt;
  logic [6:0]  exp_reg_r, exp_reg_nxt;
  logic [2:0]  skip_r, skip_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic [7:0]  crc_r, crc_nxt;
  logic [31:0] data_r, data_nxt;
  status_t     err_r, err_nxt;

  always_comb begin
    pending_nxt = pending_r;
    exp_reg_nxt = exp_reg_r;
    skip_nxt    = skip_r;
    idx_nxt     = idx_r;
    crc_nxt     = crc_r;
    data_nxt    = data_r;
    err_nxt     = err_r;
    reply.done      = 1'b0;
    reply.read_data = data_r;
    reply.status    = err_r;
    if (rx_byte != crc_r && err_r == ST_OK) begin
      reply.status = ST_BAD_CRC;
    end
    if (accept) begin
      case (action)
        ACT_READ: begin
          pending_nxt = 1'b1;
          exp_reg_nxt = reg_addr;
          skip_nxt    = skip_cfg;
          idx_nxt     = '0;
          crc_nxt     = '0;
          data_nxt    = '0;
          err_nxt     = ST_OK;
        end
        ACT_RXBYTE: begin
          if (pending_r) begin
            if (skip_r != '0) begin
              skip_nxt = skip_r - 3'd1;
            end else if (idx_r == 3'(REPLY_LAST)) begin
              reply.done  = 1'b1;
              pending_nxt = 1'b0;
              idx_nxt     = '0;
            end else begin
              case (idx_r)
                3'd0: begin
                  if (rx_byte != SYNC_BYTE && err_r == ST_OK) begin
                    err_nxt = ST_BAD_SYNC;
                  end
                end
                3'd1: begin
                  if (rx_byte != MASTER_ADDR && err_r == ST_OK) begin
                    err_nxt = ST_BAD_MASTER;
                  end
                end
                3'd2: begin
                  if (rx_byte != {1'b0, exp_reg_r} && err_r == ST_OK) begin
                    err_nxt = ST_BAD_REG;
                  end
                end
                default: begin
                  data_nxt = {data_r[23:0], rx_byte};
                end
              endcase
              crc_nxt = crc8_byte(crc_r, rx_byte);
              idx_nxt = idx_r + 3'd1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 1'b0;
      exp_reg_r <= '0;
      skip_r    <= '0;
      idx_r     <= '0;
      crc_r     <= '0;
      data_r    <= '0;
      err_r     <= ST_OK;
    end else begin
      pending_r <= pending_nxt;
      exp_reg_r <= exp_reg_nxt;
      skip_r    <= skip_nxt;
      idx_r     <= idx_nxt;
      crc_r     <= crc_nxt;
      data_r    <= data_nxt;
      err_r     <= err_nxt;
    end
  end

endmodule

>>> hdl/swu_tx_sequencer.sv
`timescale 1ns / 1ps

module swu_tx_sequencer
  import swu_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  logic [1:0]  action,
  input  logic [6:0]  reg_addr,
  input  logic [31:0] write_data,
  input  logic [7:0]  node_address,
  input  reply_t      reply,
  output logic        can_accept,
  swu_out_if.source   out_ch
);

  logic        busy_r, busy_nxt;
  logic        kind_r, kind_nxt;
  logic [2:0]  rem_r, rem_nxt;
  logic [55:0] buf_r, buf_nxt;
  logic [7:0]  crc_r, crc_nxt;
  logic [31:0] rdata_r, rdata_nxt;
  logic [2:0]  status_r, status_nxt;
  logic        pop;
  logic        finish;

  assign pop        = busy_r && out_ch.ready;
  assign finish     = pop && (kind_r == KIND_REPLY || rem_r == '0);
  assign can_accept = !busy_r || finish;

  always_comb begin
    busy_nxt   = busy_r;
    kind_nxt   = kind_r;
    rem_nxt    = rem_r;
    buf_nxt    = buf_r;
    crc_nxt    = crc_r;
    rdata_nxt  = rdata_r;
    status_nxt = status_r;
    if (finish) begin
      busy_nxt = 1'b0;
    end else if (pop) begin
      crc_nxt = crc8_byte(crc_r, buf_r[55:48]);
      buf_nxt = {buf_r[47:0], 8'h00};
      rem_nxt = rem_r - 3'd1;
    end
    if (accept) begin
      case (action)
        ACT_WRITE: begin
          busy_nxt = 1'b1;
          kind_nxt = KIND_TX;
          rem_nxt  = 3'(WR_BODY_BYTES);
          crc_nxt  = '0;
          buf_nxt  = {SYNC_BYTE, node_address, {1'b0, reg_addr} | WRITE_FLAG, write_data};
        end
        ACT_READ: begin
          busy_nxt = 1'b1;
          kind_nxt = KIND_TX;
          rem_nxt  = 3'(RD_BODY_BYTES);
          crc_nxt  = '0;
          buf_nxt  = {SYNC_BYTE, node_address, {1'b0, reg_addr}, 32'h0};
        end
        default: begin
          if (reply.done) begin
            busy_nxt   = 1'b1;
            kind_nxt   = KIND_REPLY;
            rdata_nxt  = reply.read_data;
            status_nxt = reply.status;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      kind_r <= KIND_TX;
      rem_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      kind_r <= kind_nxt;
      rem_r  <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r    <= buf_nxt;
    crc_r    <= crc_nxt;
    rdata_r  <= rdata_nxt;
    status_r <= status_nxt;
  end

  always_comb begin
    out_ch.valid        = busy_r;
    out_ch.kind         = kind_r;
    out_ch.tx_byte      = '0;
    out_ch.last         = 1'b0;
    out_ch.read_data    = '0;
    out_ch.reply_status = '0;
    if (kind_r == KIND_REPLY) begin
      out_ch.read_data    = rdata_r;
      out_ch.reply_status = status_r;
    end else if (rem_r == '0) begin
      out_ch.tx_byte = crc_r;
      out_ch.last    = 1'b1;
    end else begin
      out_ch.tx_byte = buf_r[55:48];
    end
  end

endmodule

>>> hdl/single_wire_uart_datagram_codec.sv
`timescale 1ns / 1ps
// Channel   Direction  Carries
// in_ch     sink       write request, read request or received byte
// out_ch    source     transmit byte or completed read reply
// cfg_*     write      node address (index 0), reply skip count (index 1)
//
// A write request yields eight results and a read request four, one per cycle
// while out_ch is ready, with the CRC built up byte by byte as the datagram goes out.
// The next request is taken in the cycle its predecessor's last result leaves, so a
// stream runs at one result per cycle; a byte emits nothing unless it ends a reply.
// Reset is synchronous and active low; it clears the parser and empties the output.
// A stalled output holds its result and blocks new requests until it is taken.

module single_wire_uart_datagram_codec
  import swu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  swu_in_if.sink     in_ch,
  swu_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_wdata
);

  logic [7:0] node_address_r;
  logic [2:0] reply_skip_r;
  logic       accept;
  logic       can_accept;
  reply_t     reply;

  assign in_ch.ready = can_accept;
  assign accept      = in_ch.valid && can_accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_address_r <= '0;
      reply_skip_r   <= 3'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NODE_ADDRESS: node_address_r <= cfg_wdata;
        CFG_REPLY_SKIP:   reply_skip_r   <= cfg_wdata[2:0];
        default: begin
        end
      endcase
    end
  end

  swu_reply_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .action   (in_ch.action),
    .reg_addr (in_ch.reg_addr),
    .rx_byte  (in_ch.rx_byte),
    .skip_cfg (reply_skip_r),
    .reply    (reply)
  );

  swu_tx_sequencer u_sequencer (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .action       (in_ch.action),
    .reg_addr     (in_ch.reg_addr),
    .write_data   (in_ch.write_data),
    .node_address (node_address_r),
    .reply        (reply),
    .can_accept   (can_accept),
    .out_ch       (out_ch)
  );

endmodule

>>> dv/single_wire_uart_datagram_codec_tb.sv
`timescale 1ns / 1ps

import swu_pkg::*;

class datagram_scoreboard;
  typedef struct {
    logic        kind;
    logic [7:0]  tx_byte;
    logic        last;
    logic [31:0] read_data;
    status_t     status;
  } codec_result_t;

  logic [7:0]    slave_cfg;
  logic [2:0]    skip_cfg;
  bit            read_armed;
  logic [6:0]    armed_reg;
  logic [2:0]    skip_left;
  logic [2:0]    reply_pos;
  logic [7:0]    reply_crc;
  logic [31:0]   reply_data;
  status_t       reply_err;
  codec_result_t expected_q[$];
  int            mismatches;

  function new();
    slave_cfg  = 8'h00;
    skip_cfg   = 3'd1;
    read_armed = 1'b0;
    armed_reg  = 7'h00;
    skip_left  = 3'd0;
    reply_pos  = 3'd0;
    reply_crc  = 8'h00;
    reply_data = 32'h0;
    reply_err  = ST_OK;
    mismatches = 0;
  endfunction

  static function logic [7:0] crc_update(logic [7:0] crc, logic [7:0] b);
    logic [7:0] c;
    c = crc;
    for (int k = 0; k < 8; k++) begin
      if (c[7] ^ b[k]) c = {c[6:0], 1'b0} ^ CRC_POLY;
      else c = {c[6:0], 1'b0};
    end
    return c;
  endfunction

  function void configure(logic index, logic [7:0] value);
    if (index == CFG_NODE_ADDRESS) slave_cfg = value;
    else skip_cfg = value[2:0];
  endfunction

  // Returns 1 when the request changes what the codec does or emits.
  function bit note_request(logic [1:0] act, logic [6:0] reg_addr, logic [31:0] wdata,
                            logic [7:0] rx);
    logic [7:0]    frame[8];
    logic [7:0]    crc;
    int            count;
    codec_result_t res;
    crc = 8'h00;
    frame[0] = SYNC_BYTE;
    frame[1] = slave_cfg;
    if (act == ACT_WRITE) begin
      frame[2] = WRITE_FLAG | {1'b0, reg_addr};
      {frame[3], frame[4], frame[5], frame[6]} = wdata;
      count = WR_BODY_BYTES + 1;
    end else if (act == ACT_READ) begin
      frame[2] = {1'b0, reg_addr};
      count = RD_BODY_BYTES + 1;
      read_armed = 1'b1;
      armed_reg  = reg_addr;
      skip_left  = skip_cfg;
      reply_pos  = 3'd0;
      reply_crc  = 8'h00;
      reply_data = 32'h0;
      reply_err  = ST_OK;
    end else if (act == ACT_RXBYTE) begin
      return take_byte(rx);
    end else begin
      return 1'b0;
    end
    for (int i = 0; i < count - 1; i++) crc = crc_update(crc, frame[i]);
    frame[count - 1] = crc;
    for (int i = 0; i < count; i++) begin
      res.kind      = KIND_TX;
      res.tx_byte   = frame[i];
      res.last      = (i == count - 1);
      res.read_data = 32'h0;
      res.status    = ST_OK;
      expected_q.push_back(res);
    end
    return 1'b1;
  endfunction

  function bit take_byte(logic [7:0] rx);
    codec_result_t res;
    if (!read_armed) return 1'b0;
    if (skip_left != 3'd0) begin
      skip_left--;
      return 1'b1;
    end
    if (reply_pos == REPLY_LAST) begin
      if (rx != reply_crc && reply_err == ST_OK) reply_err = ST_BAD_CRC;
      res.kind      = KIND_REPLY;
      res.tx_byte   = 8'h00;
      res.last      = 1'b0;
      res.read_data = reply_data;
      res.status    = reply_err;
      expected_q.push_back(res);
      read_armed = 1'b0;
      reply_pos  = 3'd0;
      return 1'b1;
    end
    case (reply_pos)
      3'd0: if (rx != SYNC_BYTE && reply_err == ST_OK) reply_err = ST_BAD_SYNC;
      3'd1: if (rx != MASTER_ADDR && reply_err == ST_OK) reply_err = ST_BAD_MASTER;
      3'd2: if (rx != {1'b0, armed_reg} && reply_err == ST_OK) reply_err = ST_BAD_REG;
      default: reply_data = {reply_data[23:0], rx};
    endcase
    reply_crc = crc_update(reply_crc, rx);
    reply_pos++;
    return 1'b1;
  endfunction

  task report(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    $display("%0t: mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  task check_result(logic kind, logic [7:0] tx_byte, logic last, logic [31:0] read_data,
                    logic [2:0] status);
    codec_result_t want;
    if (expected_q.size() == 0) begin
      report("result with nothing outstanding", 32'({kind, tx_byte}), 32'h0);
      return;
    end
    want = expected_q.pop_front();
    if (kind !== want.kind) report("kind", 32'(kind), 32'(want.kind));
    if (tx_byte !== want.tx_byte) report("tx_byte", 32'(tx_byte), 32'(want.tx_byte));
    if (last !== want.last) report("last", 32'(last), 32'(want.last));
    if (read_data !== want.read_data) report("read_data", read_data, want.read_data);
    if (status !== want.status) report("reply_status", 32'(status), 32'(want.status));
  endtask

  function int outstanding();
    return expected_q.size();
  endfunction
endclass

module single_wire_uart_datagram_codec_tb;
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int HOLD_CYCLES     = 80;
  localparam int SETTLE_CYCLES   = 6;
  localparam int WATCHDOG_LIMIT  = 1000;
  localparam int ITEMS_PER_PHASE = 80;
  localparam int PHASES          = 5;

  typedef enum int {
    FAULT_NONE,
    FAULT_SYNC,
    FAULT_MASTER,
    FAULT_REG,
    FAULT_REG_TOP,
    FAULT_CRC,
    FAULT_GARBLE
  } reply_fault_t;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic       cfg_index;
  logic [7:0] cfg_wdata;

  swu_in_if  in_ch();
  swu_out_if out_ch();

  datagram_scoreboard sb;
  int         items_taken;
  int         idle_cycles;
  bit         tx_no_idle;
  bit         rx_no_idle;
  bit         hold_request;
  logic [2:0] link_skip;

  single_wire_uart_datagram_codec dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      if (sb.note_request(in_ch.action, in_ch.reg_addr, in_ch.write_data, in_ch.rx_byte))
        items_taken++;
    end
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.kind, out_ch.tx_byte, out_ch.last, out_ch.read_data,
                      out_ch.reply_status);
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("single_wire_uart_datagram_codec_tb NOT OK");
      $finish;
    end
  end

  function automatic int draw_gap(bit no_idle);
    if (no_idle || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 17);
  endfunction

  initial begin
    int stall;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (hold_request) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
      end
      stall = draw_gap(rx_no_idle);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      @(negedge clk);
    end
  end

  task automatic send_item(logic [1:0] act, logic [6:0] reg_addr, logic [31:0] wdata,
                           logic [7:0] rx);
    int gap;
    gap = draw_gap(tx_no_idle);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.action     <= act;
    in_ch.reg_addr   <= reg_addr;
    in_ch.write_data <= wdata;
    in_ch.rx_byte    <= rx;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    @(negedge clk);
  endtask

  // Sends the skipped lead-in and then a reply, stopping after keep bytes in all,
  // with the odd unrelated request slipped in between.
  task automatic send_reply(logic [6:0] want_reg, reply_fault_t fault, int keep);
    logic [7:0]  frame[8];
    logic [31:0] value;
    int          total;
    value = $urandom;
    frame[0] = SYNC_BYTE;
    frame[1] = MASTER_ADDR;
    frame[2] = {1'b0, want_reg};
    {frame[3], frame[4], frame[5], frame[6]} = value;
    case (fault)
      FAULT_SYNC:    frame[0] ^= 8'($urandom_range(1, 255));
      FAULT_MASTER:  frame[1] ^= 8'($urandom_range(1, 255));
      FAULT_REG:     frame[2] ^= {1'b0, 7'($urandom_range(1, 127))};
      FAULT_REG_TOP: frame[2][7] = 1'b1;
      FAULT_GARBLE:  for (int i = 0; i < 7; i++) frame[i] = 8'($urandom);
      default: ;
    endcase
    frame[7] = 8'h00;
    for (int i = 0; i < 7; i++) frame[7] = crc8_byte(frame[7], frame[i]);
    if (fault == FAULT_CRC) frame[7] ^= 8'($urandom_range(1, 255));
    if (fault == FAULT_GARBLE && $urandom_range(0, 1) == 1) frame[7] = 8'($urandom);
    total = link_skip + 8;
    for (int i = 0; i < total && i < keep; i++) begin
      if ($urandom_range(0, 19) == 0) begin
        if ($urandom_range(0, 1) == 1)
          send_item(ACT_WRITE, 7'($urandom), $urandom, 8'($urandom));
        else send_item(ACT_UNUSED, 7'($urandom), $urandom, 8'($urandom));
      end
      send_item(ACT_RXBYTE, 7'($urandom), $urandom,
                (i < link_skip) ? 8'($urandom) : frame[i - link_skip]);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (sb.outstanding() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_link(logic [7:0] node, logic [2:0] skip);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_NODE_ADDRESS;
    cfg_wdata <= node;
    @(negedge clk);
    cfg_index <= CFG_REPLY_SKIP;
    cfg_wdata <= {5'($urandom), skip};
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.configure(CFG_NODE_ADDRESS, node);
    sb.configure(CFG_REPLY_SKIP, {5'b0, skip});
    link_skip = skip;
  endtask

  initial begin
    int           pick;
    logic [6:0]   want_reg;
    reply_fault_t fault;
    sb               = new();
    items_taken      = 0;
    idle_cycles      = 0;
    tx_no_idle       = 1'b0;
    rx_no_idle       = 1'b0;
    hold_request     = 1'b0;
    link_skip        = 3'd1;
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = CFG_NODE_ADDRESS;
    cfg_wdata        = 8'h00;
    in_ch.valid      = 1'b0;
    in_ch.action     = ACT_WRITE;
    in_ch.reg_addr   = 7'h00;
    in_ch.write_data = 32'h0;
    in_ch.rx_byte    = 8'h00;
    out_ch.ready     = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_item(ACT_RXBYTE, 7'h00, 32'h0, SYNC_BYTE);
    send_item(ACT_UNUSED, 7'h7F, 32'hFFFF_FFFF, 8'hFF);
    send_item(ACT_WRITE, 7'h00, 32'h0000_0000, 8'h00);
    send_item(ACT_WRITE, 7'h7F, 32'hFFFF_FFFF, 8'hFF);
    send_item(ACT_READ, 7'h7F, 32'h0, 8'h00);
    send_item(ACT_READ, 7'h00, 32'h0, 8'h00);
    send_item(ACT_WRITE, 7'h2A, 32'hA55A_00FF, 8'h00);
    send_item(ACT_UNUSED, 7'h00, 32'h0, 8'h00);
    send_reply(7'h00, FAULT_NONE, 16);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      case (p)
        0: set_link(8'h00, 3'd0);
        1: set_link(8'hFF, 3'd7);
        2: set_link(8'hA5, 3'd1);
        default: set_link(8'($urandom), 3'($urandom));
      endcase
      tx_no_idle = ($urandom_range(0, 3) == 0);
      rx_no_idle = ($urandom_range(0, 3) == 0);
      if (p == 2) begin
        // The receiver stops for a long while so that the codec backs up.
        hold_request = 1'b1;
        tx_no_idle   = 1'b1;
        repeat (6) send_item(ACT_WRITE, 7'($urandom), $urandom, 8'($urandom));
        tx_no_idle = 1'b0;
      end
      while (items_taken < ITEMS_PER_PHASE * (p + 1)) begin
        if ($urandom_range(0, 15) == 0) tx_no_idle = !tx_no_idle;
        if ($urandom_range(0, 15) == 0) rx_no_idle = !rx_no_idle;
        pick     = $urandom_range(0, 99);
        want_reg = 7'($urandom);
        if (pick < 45) begin
          send_item(ACT_READ, want_reg, $urandom, 8'($urandom));
          fault = ($urandom_range(0, 1) == 1) ? FAULT_NONE
                : reply_fault_t'($urandom_range(FAULT_SYNC, FAULT_GARBLE));
          send_reply(want_reg, fault,
                     ($urandom_range(0, 9) == 0) ? $urandom_range(0, link_skip + 7) : 16);
        end else if (pick < 75) begin
          send_item(ACT_WRITE, want_reg, $urandom, 8'($urandom));
        end else if (pick < 85) begin
          send_item(ACT_READ, want_reg, $urandom, 8'($urandom));
        end else begin
          send_item(($urandom_range(0, 1) == 1) ? ACT_RXBYTE : ACT_UNUSED,
                    want_reg, $urandom, 8'($urandom));
        end
      end
    end

    drain();
    if (sb.mismatches == 0) begin
      $display("single_wire_uart_datagram_codec_tb OK");
    end else begin
      $display("single_wire_uart_datagram_codec_tb NOT OK");
    end
    $finish;
  end
endmodule
